/* rtl/stable_sorted_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// Stable sorted priority queue: assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication check
`define SSPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sspq same-cycle check failed");

// Next-cycle implication check
`define SSPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sspq next-cycle check failed");

`endif

/* rtl/sspq_pkg.sv */
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types, codes and defaults for the stable sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sspq_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned PrioW           = 16;
  localparam int unsigned PayloadW        = 32;
  localparam int unsigned CountW          = 5;

  // Request operation codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_QUERY = 2'd2
  } sspq_mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } sspq_status_e;

  // Contents of one cell
  typedef struct packed {
    logic                     valid;
    logic signed [PrioW-1:0]  prio;
    logic [PayloadW-1:0]      payload;
  } sspq_entry_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [PrioW-1:0]  prio;
    logic [PayloadW-1:0]      payload;
  } sspq_ctrl_t;

endpackage

/* rtl/sspq_cell.sv */
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert,
// shifts left on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspq_cell
  import sspq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sspq_ctrl_t  ctrl_i,
  input  sspq_entry_t left_i,
  input  logic        left_gt_i,
  input  sspq_entry_t right_i,
  output sspq_entry_t ent_o,
  output logic        gt_o
);

  logic                    valid_q, valid_d;
  logic signed [PrioW-1:0] prio_q, prio_d;
  logic [PayloadW-1:0]     payload_q, payload_d;

  // Held entry leaves after the new one (strictly greater priority)
  assign gt_o = valid_q && (prio_q > ctrl_i.prio);

  // Next contents
  always_comb begin
    valid_d   = valid_q;
    prio_d    = prio_q;
    payload_d = payload_q;
    if (ctrl_i.push) begin
      valid_d = valid_q | left_i.valid;
      if (left_gt_i) begin
        prio_d    = left_i.prio;
        payload_d = left_i.payload;
      end else if (gt_o || !valid_q) begin
        prio_d    = ctrl_i.prio;
        payload_d = ctrl_i.payload;
      end
    end else if (ctrl_i.pop) begin
      valid_d   = right_i.valid;
      prio_d    = right_i.prio;
      payload_d = right_i.payload;
    end
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry data, no reset
  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign ent_o = '{valid: valid_q, prio: prio_q, payload: payload_q};

endmodule

/* rtl/stable_sorted_priority_queue.sv */
// Timing: a request accepted at one edge has its result registered onto the ports, with done_o
// high for a single cycle, in the following cycle. Throughput: one request per cycle; busy stays
// low, since every cell of the chain compares and shifts in parallel.
// Reset: asynchronous, active low; empties the queue (all cells invalid, count zero).
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded min-priority queue built as a chain of cells kept in ascending
// priority order; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_sorted_priority_queue_macros.svh"

module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode_i,
  input  logic signed [PrioW-1:0] priority_req_i,
  input  logic [PayloadW-1:0]     payload_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic                    head_valid_o,
  output logic signed [PrioW-1:0] head_priority_o,
  output logic [PayloadW-1:0]     head_payload_o,
  output logic [CountW-1:0]       entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  sspq_entry_t          ent   [CAPACITY];
  logic [CAPACITY-1:0]  gt;
  sspq_ctrl_t           ctrl;
  logic                 accept;
  logic                 full, empty;
  sspq_status_e         status_d, status_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW+CountW-1:0] cnt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = ent[CAPACITY-1].valid;
  assign empty  = !ent[0].valid;

  // Decode the request into cell control
  always_comb begin
    ctrl     = '{push: 1'b0, pop: 1'b0, prio: priority_req_i, payload: payload_i};
    status_d = ST_OK;
    cnt_d    = cnt_q;
    if (accept) begin
      unique case (mode_i)
        MODE_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            cnt_d     = cnt_q + 1'b1;
          end
        end
        MODE_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            cnt_d    = cnt_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sspq_entry_t left_ent, right_ent;
    logic        left_gt;
    if (i == 0) begin : g_first
      assign left_ent = '{valid: 1'b1, prio: '0, payload: '0};
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_gt  = gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '{valid: 1'b0, prio: '0, payload: '0};
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end
    sspq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .left_i   (left_ent),
      .left_gt_i(left_gt),
      .right_i  (right_ent),
      .ent_o    (ent[i]),
      .gt_o     (gt[i])
    );
  end

  // Count, strobe and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      cnt_q    <= cnt_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  // Result ports; head comes straight from the first cell
  assign cnt_ext         = {{CountW{1'b0}}, cnt_q};
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign head_valid_o    = ent[0].valid;
  assign head_priority_o = ent[0].valid ? ent[0].prio : '0;
  assign head_payload_o  = ent[0].valid ? ent[0].payload : '0;
  assign entry_count_o   = cnt_ext[CountW-1:0];

  // Checks
  `SSPQ_ASSERT_NEXT(a_done_follows_accept, accept, done_o)
  `SSPQ_ASSERT_NEXT(a_no_done_without_accept, !accept, !done_o)
  `SSPQ_ASSERT_NOW(a_head_matches_count, 1'b1, head_valid_o == (cnt_q != '0))
  `SSPQ_ASSERT_NOW(a_full_status_count, done_o && (status_q == ST_FULL), cnt_q == CntW'(CAPACITY))

endmodule

/* bench/tb_stable_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue
// Self-checking bench for the stable sorted priority queue. A directed table
// covers the empty and full corners, the priority extremes and equal-priority
// ordering. Random request phases follow, some biased toward filling and some
// toward draining. A shadow copy of the sorted slots predicts every result that a typed table row does not give.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue;
  import sspq_pkg::*;

  localparam int          CAPACITY      = DefaultCapacity;
  localparam int          DIRECTED_ROWS = 24;
  localparam int          RANDOM_ITEMS  = 950 - DIRECTED_ROWS;
  // Unused operation code; the queue treats it as a query
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;

  // One result as seen on the ports
  typedef struct packed {
    logic [1:0]              status;
    logic                    head_valid;
    logic signed [PrioW-1:0] head_prio;
    logic [PayloadW-1:0]     head_payload;
    logic [CountW-1:0]       count;
  } head_report_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [1:0]              mode;
    logic signed [PrioW-1:0] prio;
    logic [PayloadW-1:0]     payload;
    logic                    typed;
    head_report_t            report;
  } stim_row_t;

  localparam head_report_t EMPTY_OK = '{ST_OK, 1'b0, '0, '0, '0};
  localparam head_report_t PREDICT  = '0;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic [1:0]              mode_i         = MODE_QUERY;
  logic signed [PrioW-1:0] priority_req_i = '0;
  logic [PayloadW-1:0]     payload_i      = '0;
  logic                    busy;
  logic                    done_o;
  logic [1:0]              status_o;
  logic                    head_valid_o;
  logic signed [PrioW-1:0] head_priority_o;
  logic [PayloadW-1:0]     head_payload_o;
  logic [CountW-1:0]       entry_count_o;

  // Shadow of the sorted slots
  logic signed [PrioW-1:0] shadow_prio    [CAPACITY];
  logic [PayloadW-1:0]     shadow_payload [CAPACITY];
  int                      shadow_count = 0;

  head_report_t expected_heads [$];
  int           mismatch_count = 0;
  int           burst_left     = 1;

  stable_sorted_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .priority_req_i (priority_req_i),
    .payload_i      (payload_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .head_valid_o   (head_valid_o),
    .head_priority_o(head_priority_o),
    .head_payload_o (head_payload_o),
    .entry_count_o  (entry_count_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the queue stops answering
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one request to the shadow slots and return the head report
  function automatic head_report_t apply_request(logic [1:0] m,
                                                 logic signed [PrioW-1:0] p,
                                                 logic [PayloadW-1:0] d);
    head_report_t r;
    int           pos;
    r = '0;
    r.status = ST_OK;
    if (m == MODE_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // land after every entry of lower or equal priority
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= p) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i]    = shadow_prio[i-1];
          shadow_payload[i] = shadow_payload[i-1];
        end
        shadow_prio[pos]    = p;
        shadow_payload[pos] = d;
        shadow_count++;
      end
    end else if (m == MODE_POP) begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1]    = shadow_prio[i];
          shadow_payload[i-1] = shadow_payload[i];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      r.head_valid   = 1'b1;
      r.head_prio    = shadow_prio[0];
      r.head_payload = shadow_payload[0];
    end
    r.count = shadow_count[CountW-1:0];
    return r;
  endfunction

  // Present one request, hold it until taken, then record its expectation
  task automatic send_request(input logic [1:0] m, input logic signed [PrioW-1:0] p,
                              input logic [PayloadW-1:0] d, input logic typed,
                              input head_report_t typed_report);
    head_report_t predicted;
    start          <= 1'b1;
    mode_i         <= m;
    priority_req_i <= p;
    payload_i      <= d;
    do @(posedge clk_i); while (busy);
    predicted = apply_request(m, p, d);
    expected_heads.push_back(typed ? typed_report : predicted);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Sender bursts: random burst length, random gap, now and then a long run
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_heads.size() != 0);
  endtask

  // Result checker: each strobe is matched against the oldest expectation
  always @(posedge clk_i) begin
    head_report_t got;
    head_report_t want;
    if (rst_ni && done_o) begin
      got = '{status_o, head_valid_o, head_priority_o, head_payload_o, entry_count_o};
      if (expected_heads.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_heads.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.head_valid !== want.head_valid) begin
          $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
          mismatch_count++;
        end
        if (got.head_prio !== want.head_prio) begin
          $error("head_priority: expected %0d, got %0d", want.head_prio, got.head_prio);
          mismatch_count++;
        end
        if (got.head_payload !== want.head_payload) begin
          $error("head_payload: expected %h, got %h", want.head_payload, got.head_payload);
          mismatch_count++;
        end
        if (got.count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, got.count);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t               directed_rows [DIRECTED_ROWS];
    logic [1:0]              m;
    logic signed [PrioW-1:0] p;
    int                      sent_items;
    int                      phase_len;
    int                      push_pct;
    int                      prio_style;
    int                      roll;

    // empty corners, both extremes, equal priorities, fill to capacity, full push
    directed_rows = '{
      '{MODE_QUERY,  16'sd0,    32'h0000_0000, 1'b1, EMPTY_OK},
      '{MODE_POP,    16'sd0,    32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, '0, '0, '0}},
      '{MODE_UNUSED, -16'sd1,   32'hFFFF_FFFF, 1'b1, EMPTY_OK},
      '{MODE_PUSH,   16'sh7FFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK, 1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 5'd1}},
      '{MODE_PUSH,   16'sh8000, 32'h0000_0000, 1'b1,
        '{ST_OK, 1'b1, 16'sh8000, 32'h0000_0000, 5'd2}},
      '{MODE_PUSH,   16'sd5,    32'h0000_0001, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd5,    32'h0000_0002, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd5,    32'h0000_0003, 1'b0, PREDICT},
      '{MODE_PUSH,   -16'sd1,   32'h5555_5555, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd0,    32'hAAAA_AAAA, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sh8000, 32'h0000_0011, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sh7FFF, 32'h8000_0000, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd1,    32'h1234_5678, 1'b0, PREDICT},
      '{MODE_PUSH,   -16'sd2,   32'h8765_4321, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd100,  32'h0F0F_0F0F, 1'b0, PREDICT},
      '{MODE_PUSH,   -16'sd100, 32'hF0F0_F0F0, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd7,    32'h0000_0007, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd5,    32'h0000_0004, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd3,    32'h0000_0003, 1'b0, PREDICT},
      '{MODE_PUSH,   16'sd0,    32'hDEAD_BEEF, 1'b1,
        '{ST_FULL, 1'b1, 16'sh8000, 32'h0000_0000, 5'd16}},
      '{MODE_UNUSED, 16'sd9,    32'h0000_0009, 1'b0, PREDICT},
      '{MODE_POP,    16'sd0,    32'h0000_0000, 1'b0, PREDICT},
      '{MODE_POP,    16'sd0,    32'h0000_0000, 1'b0, PREDICT},
      '{MODE_QUERY,  16'sd0,    32'h0000_0000, 1'b0, PREDICT}
    };

    // hold reset low, then release it
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].mode, directed_rows[i].prio, directed_rows[i].payload,
                   directed_rows[i].typed, directed_rows[i].report);
      pace_sender();
    end
    drain_results();

    // random phases with a fill, balanced or drain bias
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      phase_len  = $urandom_range(20, 80);
      prio_style = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int k = 0; k < phase_len && sent_items < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5)                               m = MODE_UNUSED;
        else if (roll < 12)                         m = MODE_QUERY;
        else if (roll < 12 + (push_pct * 88) / 100) m = MODE_PUSH;
        else                                        m = MODE_POP;
        // narrow range forces ties; full range and extremes cover every bit
        case (prio_style)
          0:       p = $signed(16'($urandom_range(0, 8))) - 16'sd4;
          1:       p = 16'($urandom());
          default: begin
            case ($urandom_range(0, 4))
              0:       p = 16'sh8000;
              1:       p = 16'sh7FFF;
              2:       p = -16'sd1;
              3:       p = 16'sd0;
              default: p = 16'($urandom());
            endcase
          end
        endcase
        send_request(m, p, $urandom(), 1'b0, PREDICT);
        sent_items++;
        pace_sender();
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // wind down: no more requests, let the last results land
    start <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
